// File: rtl/stf_pkg.sv
// stf_pkg: shared constants, payload structs and the micro-op table of the similarity fit
`timescale 1ns / 1ps
`default_nettype none
package stf_pkg;

	localparam int MAX_PAIRS     = 256;
	localparam int OUT_FRAC_BITS = 16;
	localparam int COUNT_W       = 9;
	localparam int DIV_STEPS     = 64 + OUT_FRAC_BITS;
	localparam int SQRT_STEPS    = 32;
	localparam int STEP_W        = 7;
	localparam int UOP_W         = 5;

	// micro-op program layout
	localparam logic [UOP_W-1:0] UOP_ACC_FIRST   = 5'd0;
	localparam logic [UOP_W-1:0] UOP_ACC_LAST    = 5'd6;
	localparam logic [UOP_W-1:0] UOP_SOLVE_FIRST = 5'd7;
	localparam logic [UOP_W-1:0] UOP_SOLVE_LAST  = 5'd19;
	localparam logic [UOP_W-1:0] UOP_SQ_FIRST    = 5'd20;
	localparam logic [UOP_W-1:0] UOP_SQ_LAST     = 5'd22;

	typedef struct packed {
		logic signed [23:0] ref_x;
		logic signed [23:0] ref_y;
		logic signed [23:0] tgt_x;
		logic signed [23:0] tgt_y;
		logic               last_point;
	} pair_t;

	typedef struct packed {
		logic signed [31:0]   rot_cos;
		logic signed [31:0]   rot_sin;
		logic [30:0]          scale_out;
		logic                 degenerate;
		logic                 overflowed;
		logic [COUNT_W-1:0]   pairs_used;
	} fit_t;

	// multiplier operand pairs
	typedef enum logic [4:0] {
		MS_NONE, MS_RXRX, MS_RYRY, MS_RXTX, MS_RYTY, MS_RXTY, MS_RYTX,
		MS_NELO, MS_NEHI, MS_SXSX, MS_SYSY, MS_NDLO, MS_NDHI, MS_SXTX,
		MS_SYTY, MS_NCLO, MS_NCHI, MS_SXTY, MS_SYTX, MS_AA, MS_BB
	} mul_sel_t;

	// what happens to the registered product
	typedef enum logic [4:0] {
		AO_NONE, AO_EN_ADD, AO_DOT_ADD, AO_CR_ADD, AO_CR_SUB,
		AO_E_SET, AO_E_ADDH, AO_E_SUB, AO_D_SET, AO_D_ADDH, AO_D_SUB,
		AO_C_SET, AO_C_ADDH, AO_C_SUB, AO_C_ADD, AO_S_SET, AO_S_ADD
	} acc_op_t;

	typedef struct packed {
		mul_sel_t ms;
		acc_op_t  ao;
	} uop_t;

	typedef struct packed {
		logic load;
		uop_t uop;
		logic div_start;
		logic div_src_c;
		logic div_step;
		logic div_finish;
		logic div_dst_b;
		logic sqrt_start;
		logic sqrt_step;
		logic sqrt_finish;
		logic out_load;
	} stf_cmd_t;

	typedef struct packed {
		logic full;
		logic e_zero;
	} stf_status_t;

	// product issued at step i, accumulated at step i+1
	function automatic uop_t uop_rom(input logic [UOP_W-1:0] idx);
		uop_t u;
		u = '{ms: MS_NONE, ao: AO_NONE};
		unique case (idx)
			5'd0:  u = '{ms: MS_RXRX, ao: AO_NONE};
			5'd1:  u = '{ms: MS_RYRY, ao: AO_EN_ADD};
			5'd2:  u = '{ms: MS_RXTX, ao: AO_EN_ADD};
			5'd3:  u = '{ms: MS_RYTY, ao: AO_DOT_ADD};
			5'd4:  u = '{ms: MS_RXTY, ao: AO_DOT_ADD};
			5'd5:  u = '{ms: MS_RYTX, ao: AO_CR_ADD};
			5'd6:  u = '{ms: MS_NONE, ao: AO_CR_SUB};
			5'd7:  u = '{ms: MS_NELO, ao: AO_NONE};
			5'd8:  u = '{ms: MS_NEHI, ao: AO_E_SET};
			5'd9:  u = '{ms: MS_SXSX, ao: AO_E_ADDH};
			5'd10: u = '{ms: MS_SYSY, ao: AO_E_SUB};
			5'd11: u = '{ms: MS_NDLO, ao: AO_E_SUB};
			5'd12: u = '{ms: MS_NDHI, ao: AO_D_SET};
			5'd13: u = '{ms: MS_SXTX, ao: AO_D_ADDH};
			5'd14: u = '{ms: MS_SYTY, ao: AO_D_SUB};
			5'd15: u = '{ms: MS_NCLO, ao: AO_D_SUB};
			5'd16: u = '{ms: MS_NCHI, ao: AO_C_SET};
			5'd17: u = '{ms: MS_SXTY, ao: AO_C_ADDH};
			5'd18: u = '{ms: MS_SYTX, ao: AO_C_SUB};
			5'd19: u = '{ms: MS_NONE, ao: AO_C_ADD};
			5'd20: u = '{ms: MS_AA,   ao: AO_NONE};
			5'd21: u = '{ms: MS_BB,   ao: AO_S_SET};
			5'd22: u = '{ms: MS_NONE, ao: AO_S_ADD};
			default: u = '{ms: MS_NONE, ao: AO_NONE};
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

// File: rtl/stf_datapath.sv
// stf_datapath: running sums, shared multiplier, divider, square root and result register
`timescale 1ns / 1ps
`default_nettype none
module stf_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire stf_pkg::stf_cmd_t    cmd,
	input  wire stf_pkg::pair_t       pair,
	output stf_pkg::stf_status_t      status,
	output stf_pkg::fit_t             fit
);
	import stf_pkg::*;

	logic [COUNT_W-1:0]  count_q;
	logic                excess_q;
	logic signed [31:0]  srx_q, sry_q, stx_q, sty_q;
	logic [56:0]         sen_q;
	logic [57:0]         sdot_q, scr_q;
	logic signed [23:0]  rx_q, ry_q, tx_q, ty_q;
	logic [63:0]         e_q, d_q, c_q, s_q;
	logic signed [32:0]  op_a, op_b;
	logic signed [65:0]  prod_q;

	logic [DIV_STEPS-1:0] num_q;
	logic [63:0]         rem_q;
	logic [32:0]         quo_q;
	logic                qovf_q, neg_q;
	logic signed [31:0]  a_q, b_q;
	logic [31:0]         amag_q, bmag_q;

	logic [63:0]         x_q, res_q, bit_q;
	logic [30:0]         scale_q;

	logic [64:0]         rem_sh;
	logic                rem_ge;
	logic [32:0]         q_rnd, q_lim, q_mag;
	logic                q_sat;
	logic [63:0]         sq_t;
	logic [32:0]         res_rnd;

	assign status.full   = (count_q == COUNT_W'(MAX_PAIRS));
	assign status.e_zero = (e_q == 64'd0);

	// operand selection for the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.uop.ms)
			MS_RXRX: begin op_a = 33'(rx_q); op_b = 33'(rx_q); end
			MS_RYRY: begin op_a = 33'(ry_q); op_b = 33'(ry_q); end
			MS_RXTX: begin op_a = 33'(rx_q); op_b = 33'(tx_q); end
			MS_RYTY: begin op_a = 33'(ry_q); op_b = 33'(ty_q); end
			MS_RXTY: begin op_a = 33'(rx_q); op_b = 33'(ty_q); end
			MS_RYTX: begin op_a = 33'(ry_q); op_b = 33'(tx_q); end
			MS_NELO: begin op_a = {24'd0, count_q}; op_b = {1'b0, sen_q[31:0]}; end
			MS_NEHI: begin op_a = {24'd0, count_q}; op_b = {8'd0, sen_q[56:32]}; end
			MS_SXSX: begin op_a = 33'(srx_q); op_b = 33'(srx_q); end
			MS_SYSY: begin op_a = 33'(sry_q); op_b = 33'(sry_q); end
			MS_NDLO: begin op_a = {24'd0, count_q}; op_b = {1'b0, sdot_q[31:0]}; end
			MS_NDHI: begin
				op_a = {24'd0, count_q};
				op_b = 33'(signed'(sdot_q[57:32]));
			end
			MS_SXTX: begin op_a = 33'(srx_q); op_b = 33'(stx_q); end
			MS_SYTY: begin op_a = 33'(sry_q); op_b = 33'(sty_q); end
			MS_NCLO: begin op_a = {24'd0, count_q}; op_b = {1'b0, scr_q[31:0]}; end
			MS_NCHI: begin
				op_a = {24'd0, count_q};
				op_b = 33'(signed'(scr_q[57:32]));
			end
			MS_SXTY: begin op_a = 33'(srx_q); op_b = 33'(sty_q); end
			MS_SYTX: begin op_a = 33'(sry_q); op_b = 33'(stx_q); end
			MS_AA:   begin op_a = {1'b0, amag_q}; op_b = {1'b0, amag_q}; end
			MS_BB:   begin op_a = {1'b0, bmag_q}; op_b = {1'b0, bmag_q}; end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	// divider step and rounding
	assign rem_sh = {rem_q, num_q[DIV_STEPS-1]};
	assign rem_ge = (rem_sh >= {1'b0, e_q});
	assign q_sat  = qovf_q | quo_q[32];
	assign q_rnd  = {1'b0, quo_q[31:0]} + 33'(({rem_q, 1'b0} >= {1'b0, e_q}));
	assign q_lim  = neg_q ? 33'h080000000 : 33'h07FFFFFFF;
	assign q_mag  = (q_sat || (q_rnd > q_lim)) ? q_lim : q_rnd;

	// square root step and rounding
	assign sq_t    = res_q + bit_q;
	assign res_rnd = res_q[32:0] + 33'((x_q > res_q));

	// control state: count, overflow mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			excess_q <= 1'b0;
		end else if (cmd.out_load) begin
			count_q  <= '0;
			excess_q <= 1'b0;
		end else if (cmd.load) begin
			if (status.full) begin
				excess_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srx_q  <= '0;
			sry_q  <= '0;
			stx_q  <= '0;
			sty_q  <= '0;
			sen_q  <= '0;
			sdot_q <= '0;
			scr_q  <= '0;
		end else if (cmd.out_load) begin
			srx_q  <= '0;
			sry_q  <= '0;
			stx_q  <= '0;
			sty_q  <= '0;
			sen_q  <= '0;
			sdot_q <= '0;
			scr_q  <= '0;
		end else begin
			if (cmd.load && !status.full) begin
				srx_q <= srx_q + 32'(pair.ref_x);
				sry_q <= sry_q + 32'(pair.ref_y);
				stx_q <= stx_q + 32'(pair.tgt_x);
				sty_q <= sty_q + 32'(pair.tgt_y);
			end
			case (cmd.uop.ao)
				AO_EN_ADD:  sen_q  <= sen_q + prod_q[56:0];
				AO_DOT_ADD: sdot_q <= sdot_q + prod_q[57:0];
				AO_CR_ADD:  scr_q  <= scr_q + prod_q[57:0];
				AO_CR_SUB:  scr_q  <= scr_q - prod_q[57:0];
				default: ;
			endcase
		end
	end

	// input transaction capture and centred moments
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rx_q <= pair.ref_x;
			ry_q <= pair.ref_y;
			tx_q <= pair.tgt_x;
			ty_q <= pair.tgt_y;
		end
		case (cmd.uop.ao)
			AO_E_SET:  e_q <= prod_q[63:0];
			AO_E_ADDH: e_q <= e_q + {prod_q[31:0], 32'd0};
			AO_E_SUB:  e_q <= e_q - prod_q[63:0];
			AO_D_SET:  d_q <= prod_q[63:0];
			AO_D_ADDH: d_q <= d_q + {prod_q[31:0], 32'd0};
			AO_D_SUB:  d_q <= d_q - prod_q[63:0];
			AO_C_SET:  c_q <= prod_q[63:0];
			AO_C_ADDH: c_q <= c_q + {prod_q[31:0], 32'd0};
			AO_C_SUB:  c_q <= c_q - prod_q[63:0];
			AO_C_ADD:  c_q <= c_q + prod_q[63:0];
			AO_S_SET:  s_q <= prod_q[63:0];
			AO_S_ADD:  s_q <= s_q + prod_q[63:0];
			default: ;
		endcase
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			if (cmd.div_src_c) begin
				neg_q <= c_q[63];
				num_q <= {(c_q[63] ? (64'd0 - c_q) : c_q), OUT_FRAC_BITS'(0)};
			end else begin
				neg_q <= d_q[63];
				num_q <= {(d_q[63] ? (64'd0 - d_q) : d_q), OUT_FRAC_BITS'(0)};
			end
			rem_q  <= '0;
			quo_q  <= '0;
			qovf_q <= 1'b0;
		end else if (cmd.div_step) begin
			num_q  <= {num_q[DIV_STEPS-2:0], 1'b0};
			rem_q  <= rem_ge ? 64'(rem_sh - {1'b0, e_q}) : rem_sh[63:0];
			quo_q  <= {quo_q[31:0], rem_ge};
			qovf_q <= qovf_q | quo_q[32];
		end
		if (cmd.div_finish) begin
			if (cmd.div_dst_b) begin
				bmag_q <= q_mag[31:0];
				b_q    <= neg_q ? 32'(33'd0 - q_mag) : q_mag[31:0];
			end else begin
				amag_q <= q_mag[31:0];
				a_q    <= neg_q ? 32'(33'd0 - q_mag) : q_mag[31:0];
			end
		end
	end

	// bitwise square root, two radicand bits per cycle
	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			x_q   <= s_q;
			res_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (cmd.sqrt_step) begin
			if (x_q >= sq_t) begin
				x_q   <= x_q - sq_t;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.sqrt_finish) begin
			scale_q <= (res_rnd > 33'h07FFFFFFF) ? 31'h7FFFFFFF : res_rnd[30:0];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			fit.degenerate <= status.e_zero;
			fit.overflowed <= excess_q;
			fit.pairs_used <= count_q;
			fit.rot_cos    <= status.e_zero ? 32'sd0 : a_q;
			fit.rot_sin    <= status.e_zero ? 32'sd0 : b_q;
			fit.scale_out  <= status.e_zero ? 31'd0 : scale_q;
		end
	end

endmodule
`default_nettype wire

// File: rtl/stf_ctrl.sv
// stf_ctrl: sequencer for accumulation, solve, divides, square root and result hand-off
`timescale 1ns / 1ps
`default_nettype none
module stf_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  pair_valid,
	input  wire logic                  last_point,
	output logic                       pair_stall,
	output logic                       fit_valid,
	input  wire logic                  fit_stall,
	input  wire stf_pkg::stf_status_t  status,
	output stf_pkg::stf_cmd_t          cmd
);
	import stf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_ACC, S_SOLVE, S_DIV, S_DIVEND, S_SQUARE,
		S_SQST, S_SQRT, S_SQEND, S_DONE
	} state_t;

	state_t             state_q;
	logic [UOP_W-1:0]   uop_q;
	logic [STEP_W-1:0]  cnt_q;
	logic               last_q;
	logic               divb_q;

	assign pair_stall = (state_q != S_IDLE);

	// command decode
	always_comb begin
		cmd     = '0;
		cmd.uop = '{ms: MS_NONE, ao: AO_NONE};
		unique case (state_q)
			S_IDLE:   cmd.load = pair_valid;
			S_ACC, S_SQUARE: cmd.uop = uop_rom(uop_q);
			S_SOLVE: begin
				cmd.uop = uop_rom(uop_q);
				cmd.div_start = (uop_q == UOP_SOLVE_LAST) && !status.e_zero;
			end
			S_DIV:    cmd.div_step = 1'b1;
			S_DIVEND: begin
				cmd.div_finish = 1'b1;
				cmd.div_dst_b  = divb_q;
				cmd.div_start  = !divb_q;
				cmd.div_src_c  = 1'b1;
			end
			S_SQST:   cmd.sqrt_start = 1'b1;
			S_SQRT:   cmd.sqrt_step = 1'b1;
			S_SQEND:  cmd.sqrt_finish = 1'b1;
			S_DONE:   cmd.out_load = !fit_valid || !fit_stall;
			default:  cmd = '0;
		endcase
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			uop_q     <= '0;
			cnt_q     <= '0;
			last_q    <= 1'b0;
			divb_q    <= 1'b0;
			fit_valid <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				fit_valid <= 1'b1;
			end else if (!fit_stall) begin
				fit_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pair_valid) begin
						last_q <= last_point;
						if (!status.full) begin
							state_q <= S_ACC;
							uop_q   <= UOP_ACC_FIRST;
						end else if (last_point) begin
							state_q <= S_SOLVE;
							uop_q   <= UOP_SOLVE_FIRST;
						end
					end
				end
				S_ACC: begin
					if (uop_q == UOP_ACC_LAST) begin
						if (last_q) begin
							state_q <= S_SOLVE;
							uop_q   <= UOP_SOLVE_FIRST;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						uop_q <= uop_q + 1'b1;
					end
				end
				S_SOLVE: begin
					if (uop_q == UOP_SOLVE_LAST) begin
						cnt_q  <= '0;
						divb_q <= 1'b0;
						state_q <= status.e_zero ? S_DONE : S_DIV;
					end else begin
						uop_q <= uop_q + 1'b1;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= S_DIVEND;
					end
				end
				S_DIVEND: begin
					cnt_q <= '0;
					if (divb_q) begin
						state_q <= S_SQUARE;
						uop_q   <= UOP_SQ_FIRST;
					end else begin
						divb_q  <= 1'b1;
						state_q <= S_DIV;
					end
				end
				S_SQUARE: begin
					if (uop_q == UOP_SQ_LAST) begin
						state_q <= S_SQST;
					end else begin
						uop_q <= uop_q + 1'b1;
					end
				end
				S_SQST: begin
					cnt_q   <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_W'(SQRT_STEPS - 1)) begin
						state_q <= S_SQEND;
					end
				end
				S_SQEND: state_q <= S_DONE;
				S_DONE: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/similarity_transform_fit.sv
// similarity_transform_fit: top level of the least-squares 2D similarity transform fit
//
// channel  direction  payload  handshake
// pair     in         pair_t   pair_valid / pair_stall
// fit      out        fit_t    fit_valid / fit_stall
//
// A pair transaction runs six products through the one shared 33x33 multiplier, or
// none when capacity is already full. A last pair adds the solve: the moments,
// two divides, squaring and the square root; a degenerate shape skips the divides,
// squaring and square root. arst_n clears the sums, count, overflow mark and valid
// flag; a finished fit waits in its output register, and the next pair is taken
// while it is stalled there.
`timescale 1ns / 1ps
`default_nettype none
module similarity_transform_fit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            pair_valid,
	output logic                 pair_stall,
	input  wire stf_pkg::pair_t  pair,
	output logic                 fit_valid,
	input  wire logic            fit_stall,
	output stf_pkg::fit_t        fit
);
	import stf_pkg::*;

	stf_cmd_t    cmd;
	stf_status_t status;

	stf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_valid (pair_valid),
		.last_point (pair.last_point),
		.pair_stall (pair_stall),
		.fit_valid  (fit_valid),
		.fit_stall  (fit_stall),
		.status     (status),
		.cmd        (cmd)
	);

	stf_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.pair   (pair),
		.status (status),
		.fit    (fit)
	);

endmodule
`default_nettype wire

// File: tb/tb_similarity_transform_fit.sv
// tb_similarity_transform_fit: self-checking testbench for the 2D similarity transform fit
`timescale 1ns / 1ps
`default_nettype none

// running sums and expected fits for the similarity fit
class fit_book;
	stf_pkg::fit_t want_q[$];
	int            errors;
	bit [63:0]     count;
	longint        srx, sry, stx, sty, sdot, scross;
	bit [63:0]     senergy;
	bit            excess;

	function new();
		errors = 0;
		clear();
	endfunction

	function void clear();
		count = 0; srx = 0; sry = 0; stx = 0; sty = 0;
		senergy = 0; sdot = 0; scross = 0; excess = 0;
	endfunction

	// rounded, saturated magnitude ratio in Q16.16, sign applied after rounding
	function longint quot(bit [63:0] mag, bit neg, bit [63:0] den);
		bit [63:0] ip, r, q, lim;
		ip = mag / den;
		r = mag % den;
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		if (ip >= (64'd1 << (32 - stf_pkg::OUT_FRAC_BITS)))
			q = lim;
		else begin
			q = ip;
			for (int i = 0; i < stf_pkg::OUT_FRAC_BITS; i++) begin
				r = r << 1;
				q = q << 1;
				if (r >= den) begin
					r = r - den;
					q[0] = 1'b1;
				end
			end
			if ((r << 1) >= den) q = q + 1;
			if (q > lim) q = lim;
		end
		return neg ? -longint'(q) : longint'(q);
	endfunction

	// integer square root rounded to nearest
	function bit [63:0] root(bit [63:0] v);
		bit [63:0] x, res, b;
		x = v; res = 0; b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else
				res = res >> 1;
			b = b >> 2;
		end
		if (res * res + res < v) res = res + 1;
		return res;
	endfunction

	// accumulate one accepted pair; solve on the last one
	function void note(stf_pkg::pair_t p);
		longint rx, ry, tx, ty, a, b;
		bit [63:0] e, d, c, dm, cm, am, bm, sq, scale;
		stf_pkg::fit_t f;
		rx = p.ref_x; ry = p.ref_y; tx = p.tgt_x; ty = p.tgt_y;
		a = 0; b = 0; scale = 0;
		if (count < stf_pkg::MAX_PAIRS) begin
			srx += rx; sry += ry; stx += tx; sty += ty;
			senergy += rx * rx + ry * ry;
			sdot += rx * tx + ry * ty;
			scross += rx * ty - ry * tx;
			count++;
		end else
			excess = 1;
		if (!p.last_point) return;
		e = count * senergy - srx * srx - sry * sry;
		d = count * sdot - srx * stx - sry * sty;
		c = count * scross - srx * sty + sry * stx;
		if (e != 0) begin
			dm = d[63] ? -d : d;
			cm = c[63] ? -c : c;
			a = quot(dm, d[63], e);
			b = quot(cm, c[63], e);
			am = a < 0 ? -a : a;
			bm = b < 0 ? -b : b;
			sq = root(am * am + bm * bm);
			scale = sq > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : sq;
		end
		f.rot_cos = a[31:0];
		f.rot_sin = b[31:0];
		f.scale_out = scale[30:0];
		f.degenerate = (e == 0);
		f.overflowed = excess;
		f.pairs_used = count[8:0];
		want_q = {want_q, f};
		clear();
	endfunction

	// compare one accepted fit with the oldest expectation
	function void check(stf_pkg::fit_t got);
		stf_pkg::fit_t w;
		if (want_q.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected fit transaction %p", got);
			return;
		end
		w = want_q.pop_front();
		if (got.rot_cos !== w.rot_cos || got.rot_sin !== w.rot_sin ||
			got.scale_out !== w.scale_out || got.degenerate !== w.degenerate ||
			got.overflowed !== w.overflowed || got.pairs_used !== w.pairs_used) begin
			errors++;
			if (errors <= 10) $display("fit mismatch: expected %p, got %p", w, got);
		end
	endfunction
endclass

module tb_similarity_transform_fit;
	logic           clk;
	logic           arst_n;
	logic           pair_valid;
	logic           pair_stall;
	stf_pkg::pair_t pair;
	logic           fit_valid;
	logic           fit_stall;
	stf_pkg::fit_t  fit;

	fit_book book;
	int      burst_left;
	bit      hold_off;

	similarity_transform_fit uut (
		.clk(clk), .arst_n(arst_n),
		.pair_valid(pair_valid), .pair_stall(pair_stall), .pair(pair),
		.fit_valid(fit_valid), .fit_stall(fit_stall), .fit(fit)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// offer one pair transaction, with random gaps between bursts
	task automatic send(input logic signed [23:0] rx, input logic signed [23:0] ry,
			input logic signed [23:0] tx, input logic signed [23:0] ty, input bit last);
		stf_pkg::pair_t p;
		int gap;
		p.ref_x = rx; p.ref_y = ry; p.tgt_x = tx; p.tgt_y = ty; p.last_point = last;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				pair_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		pair <= p;
		pair_valid <= 1'b1;
		do @(posedge clk); while (pair_stall);
		book.note(p);
	endtask

	// coordinate: full range, small range, or an extreme
	function automatic logic [23:0] coord();
		case ($urandom_range(0, 9))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2, 3, 4: return 24'($urandom);
			default: return 24'($signed($urandom_range(0, 16000)) - 8000);
		endcase
	endfunction

	// one random shape; mostly loose similarity of the reference
	task automatic random_shape(input int n);
		logic signed [23:0] rx, ry;
		int ca, sa, mode;
		mode = $urandom_range(0, 3);
		ca = $signed($urandom_range(0, 8)) - 4;
		sa = $signed($urandom_range(0, 8)) - 4;
		for (int i = 0; i < n; i++) begin
			rx = coord(); ry = coord();
			if (mode == 0)
				send(rx, ry, coord(), coord(), i == n - 1);
			else
				send(rx, ry, 24'(ca * (rx >>> 2) - sa * (ry >>> 2) + $signed($urandom_range(0, 20)) - 10),
					24'(sa * (rx >>> 2) + ca * (ry >>> 2)), i == n - 1);
		end
	endtask

	// reset and stimulus
	initial begin
		book = new();
		arst_n = 1'b0;
		pair_valid = 1'b0;
		pair = '0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// single pair: zero spread
		send(24'h001000, 24'h002000, 24'h003000, 24'h004000, 1);
		// identical reference points
		send(24'h7FFFFF, 24'h800000, 24'h000100, 24'h000000, 0);
		send(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 1);
		// identity and quarter turn
		send(24'h001000, 24'h000000, 24'h001000, 24'h000000, 0);
		send(24'h000000, 24'h001000, 24'h000000, 24'h001000, 1);
		send(24'h001000, 24'h000000, 24'h000000, 24'h001000, 0);
		send(24'h000000, 24'h001000, 24'hFFF000, 24'h000000, 1);
		// tiny reference spread, huge targets: saturation both signs
		send(24'h000000, 24'h000000, 24'h800000, 24'h7FFFFF, 0);
		send(24'h000001, 24'h000000, 24'h7FFFFF, 24'h800000, 1);
		send(24'h000000, 24'h000000, 24'h7FFFFF, 24'h7FFFFF, 0);
		send(24'h000001, 24'h000001, 24'h800000, 24'h800000, 1);
		// extreme corners
		send(24'h800000, 24'h800000, 24'h800000, 24'h800000, 0);
		send(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0);
		send(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 1);
		// capacity exceeded, last pair itself beyond capacity
		random_shape(258);
		// random shapes, mostly short
		for (int k = 0; k < 28; k++)
			random_shape($urandom_range(0, 9) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 6));
		pair_valid <= 1'b0;
		while (book.want_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (book.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// long hold-off once the run is under way
	initial begin
		hold_off <= 0;
		repeat (3000) @(posedge clk);
		hold_off <= 1;
		repeat (2500) @(posedge clk);
		hold_off <= 0;
	end

	// receiver stall pattern: phases of none, light and heavy stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fit_stall <= 1'b0;
		else if (hold_off)
			fit_stall <= 1'b1;
		else
			case (($time / 2560) % 3)
				0: fit_stall <= 1'b0;
				1: fit_stall <= ($urandom_range(0, 9) < 3);
				default: fit_stall <= ($urandom_range(0, 9) < 8);
			endcase
	end

	// check each accepted fit transaction
	always @(posedge clk)
		if (arst_n && fit_valid && !fit_stall)
			book.check(fit);

	// run limit
	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire
